FILE: hw/rtl/ezpt_pkg.sv
// Shared types, constants, rounding helpers and series divisors for the Euler point transform.
`default_nettype none
package ezpt_pkg;

    localparam int CW = 34;   // coefficient width, Q2.30 with headroom
    localparam int PW = 52;   // entry * coordinate product, Q32
    localparam int AW = 54;   // row accumulator, Q32
    localparam int DW = 32;   // coordinate width
    localparam int ANGW = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z     = 3'd5;

    localparam logic signed [16:0] ANG_PI      = 17'sd25736;
    localparam logic signed [16:0] ANG_HALF_PI = 17'sd12868;
    localparam logic signed [CW-1:0] Q30_ONE   = CW'(64'sd1 << 30);

    typedef logic [3:0][2:0][2:0][CW-1:0] coef_mat_t;

    // Q60 -> Q30, nearest, ties away from zero
    function automatic logic signed [CW-1:0] rnd30(input logic signed [67:0] v);
        logic [67:0] m;
        logic [67:0] r;
        m = v[67] ? 68'(-v) : 68'(v);
        r = (m + (68'd1 << 29)) >> 30;
        return v[67] ? CW'(-r) : CW'(r);
    endfunction

    // Q46 -> Q32
    function automatic logic signed [PW-1:0] rnd14(input logic signed [65:0] v);
        logic [65:0] m;
        logic [65:0] r;
        m = v[65] ? 66'(-v) : 66'(v);
        r = (m + (66'd1 << 13)) >> 14;
        return v[65] ? PW'(-r) : PW'(r);
    endfunction

    // Q32 -> Q16 with saturation to 32 bits
    function automatic logic signed [DW-1:0] rnd16_sat(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        logic [AW-1:0] r;
        logic signed [AW-1:0] s;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        r = (m + (AW'(1) << 15)) >> 16;
        s = v[AW-1] ? AW'(-r) : AW'(r);
        if (s > AW'(64'sd2147483647))
            return 32'sh7FFF_FFFF;
        else if (s < -AW'(64'sd2147483648))
            return 32'sh8000_0000;
        else
            return s[DW-1:0];
    endfunction

    // Horner divisors of the sine series
    function automatic logic [7:0] sin_div(input logic [2:0] idx);
        logic [7:0] d;
        unique case (idx)
            3'd0: d = 8'd110;
            3'd1: d = 8'd72;
            3'd2: d = 8'd42;
            3'd3: d = 8'd20;
            3'd4: d = 8'd6;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // Horner divisors of the cosine series
    function automatic logic [7:0] cos_div(input logic [2:0] idx);
        logic [7:0] d;
        unique case (idx)
            3'd0: d = 8'd132;
            3'd1: d = 8'd90;
            3'd2: d = 8'd56;
            3'd3: d = 8'd30;
            3'd4: d = 8'd12;
            3'd5: d = 8'd2;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ezpt_point_if.sv
// Input channel: one 3D point per beat.
`default_nettype none
interface ezpt_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ezpt_result_if.sv
// Output channel: moved point and its three angle partials per beat.
`default_nettype none
interface ezpt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] moved_x;
    logic signed [31:0] moved_y;
    logic signed [31:0] moved_z;
    logic signed [31:0] d_first_x;
    logic signed [31:0] d_first_y;
    logic signed [31:0] d_first_z;
    logic signed [31:0] d_second_x;
    logic signed [31:0] d_second_y;
    logic signed [31:0] d_second_z;
    logic signed [31:0] d_third_x;
    logic signed [31:0] d_third_y;
    logic signed [31:0] d_third_z;

    modport source (output valid, moved_x, moved_y, moved_z, d_first_x, d_first_y,
                    d_first_z, d_second_x, d_second_y, d_second_z, d_third_x,
                    d_third_y, d_third_z, input ready);
    modport sink   (input valid, moved_x, moved_y, moved_z, d_first_x, d_first_y,
                    d_first_z, d_second_x, d_second_y, d_second_z, d_third_x,
                    d_third_y, d_third_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ezpt_div.sv
// Signed divider by a small unsigned constant, truncating toward zero, by reciprocal.
`default_nettype none
module ezpt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [ezpt_pkg::CW-1:0] dividend,
    input  wire logic [7:0]                  divisor,
    output logic                             done,
    output logic signed [ezpt_pkg::CW-1:0]   quotient
);
    import ezpt_pkg::*;

    // magnitudes stay below 2^33, so floor(2^33/d) gives an estimate at most one low
    localparam int MW = CW - 1;
    localparam int RW = 33;
    localparam int QW = MW + 8;

    logic                 s1_reg;
    logic                 s2_reg;
    logic                 done_reg;
    logic [MW-1:0]        mag_reg;
    logic                 neg_reg;
    logic [7:0]           div_reg;
    logic [MW-1:0]        est_reg;
    logic signed [CW-1:0] quo_reg;

    logic [RW-1:0]        recip;
    logic [MW+RW-1:0]     prod;
    logic [QW-1:0]        rem;
    logic [MW-1:0]        quo_mag;

    always_comb
    begin
        unique case (div_reg)
            8'd2:    recip = 33'd4294967296;
            8'd6:    recip = 33'd1431655765;
            8'd12:   recip = 33'd715827882;
            8'd20:   recip = 33'd429496729;
            8'd30:   recip = 33'd286331153;
            8'd42:   recip = 33'd204522252;
            8'd56:   recip = 33'd153391689;
            8'd72:   recip = 33'd119304647;
            8'd90:   recip = 33'd95443717;
            8'd110:  recip = 33'd78090314;
            8'd132:  recip = 33'd65075262;
            default: recip = 33'h1_FFFF_FFFF;
        endcase
        prod    = (MW+RW)'(mag_reg) * (MW+RW)'(recip);
        // one compare and subtract lifts the estimate to the exact quotient
        rem     = QW'(mag_reg) - QW'(est_reg) * QW'(div_reg);
        quo_mag = (rem >= QW'(div_reg)) ? est_reg + 1'b1 : est_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            s2_reg   <= s1_reg && !start;
            done_reg <= s2_reg && !start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[CW-1] ? MW'(-dividend) : MW'(dividend);
            neg_reg <= dividend[CW-1];
            div_reg <= divisor;
        end
        if (s1_reg)
            est_reg <= prod[MW+RW-1:RW];
        if (s2_reg)
            quo_reg <= neg_reg ? -{1'b0, quo_mag} : {1'b0, quo_mag};
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ezpt_coef.sv
// Coefficient unit: sin/cos series and the rotation and partial matrices.
`default_nettype none
module ezpt_coef (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [ezpt_pkg::ANGW-1:0] angle_first,
    input  wire logic signed [ezpt_pkg::ANGW-1:0] angle_second,
    input  wire logic signed [ezpt_pkg::ANGW-1:0] angle_third,
    output logic                               busy,
    output ezpt_pkg::coef_mat_t                coef
);
    import ezpt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BEGIN = 4'd1;
    localparam logic [3:0] ST_ANG   = 4'd2;
    localparam logic [3:0] ST_X2    = 4'd3;
    localparam logic [3:0] ST_TMUL  = 4'd4;
    localparam logic [3:0] ST_TDIV  = 4'd5;
    localparam logic [3:0] ST_SIN   = 4'd6;
    localparam logic [3:0] ST_STORE = 4'd7;
    localparam logic [3:0] ST_PROD  = 4'd8;
    localparam logic [3:0] ST_LOAD  = 4'd9;

    localparam int NPRD = 20;

    logic [3:0] state_reg, state_next;
    logic [1:0] k_reg;
    logic [2:0] i_reg;
    logic [4:0] j_reg;
    logic       cos_mode_reg;
    logic       neg_reg;

    logic signed [CW-1:0] rx_reg, rx2_reg, rt_reg, rs_reg;
    logic signed [CW-1:0] sin_reg [0:2];
    logic signed [CW-1:0] cos_reg [0:2];
    logic signed [CW-1:0] prd_reg [0:NPRD-1];
    coef_mat_t            coef_reg;

    logic signed [ANGW-1:0] ang;
    logic signed [16:0]     ang_fold;
    logic                   ang_neg;
    logic signed [CW-1:0]   mul_a, mul_b, mul_q;
    logic [7:0]             divisor;
    logic                   last_term;
    logic                   div_done;
    logic signed [CW-1:0]   div_q;

    logic signed [CW-1:0] sa, ca, sb, cb, sc, cc;
    logic signed [CW-1:0] p1, p2, p3, p4;
    logic signed [CW-1:0] r00, r01, r10, r11, d1n;

    assign sa = sin_reg[0];
    assign ca = cos_reg[0];
    assign sb = sin_reg[1];
    assign cb = cos_reg[1];
    assign sc = sin_reg[2];
    assign cc = cos_reg[2];
    assign p1 = prd_reg[0];
    assign p2 = prd_reg[1];
    assign p3 = prd_reg[2];
    assign p4 = prd_reg[3];

    // fold into +-pi/2
    always_comb
    begin
        unique case (k_reg)
            2'd0: ang = angle_first;
            2'd1: ang = angle_second;
            default: ang = angle_third;
        endcase
        ang_neg  = 1'b0;
        ang_fold = 17'(ang);
        if (17'(ang) > ANG_HALF_PI)
        begin
            ang_fold = 17'(ang) - ANG_PI;
            ang_neg  = 1'b1;
        end
        else if (17'(ang) < -ANG_HALF_PI)
        begin
            ang_fold = 17'(ang) + ANG_PI;
            ang_neg  = 1'b1;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = rx2_reg;
        mul_b = rt_reg;
        unique case (state_reg)
            ST_X2:
            begin
                mul_a = rx_reg;
                mul_b = rx_reg;
            end
            ST_SIN:
            begin
                mul_a = rx_reg;
                mul_b = rt_reg;
            end
            ST_PROD:
            begin
                unique case (j_reg)
                    5'd0:  begin mul_a = sa; mul_b = cb; end
                    5'd1:  begin mul_a = ca; mul_b = cb; end
                    5'd2:  begin mul_a = sa; mul_b = sb; end
                    5'd3:  begin mul_a = ca; mul_b = sb; end
                    5'd4:  begin mul_a = ca; mul_b = cc; end
                    5'd5:  begin mul_a = p1; mul_b = sc; end
                    5'd6:  begin mul_a = sa; mul_b = cc; end
                    5'd7:  begin mul_a = p2; mul_b = sc; end
                    5'd8:  begin mul_a = sb; mul_b = sc; end
                    5'd9:  begin mul_a = ca; mul_b = sc; end
                    5'd10: begin mul_a = p1; mul_b = cc; end
                    5'd11: begin mul_a = sa; mul_b = sc; end
                    5'd12: begin mul_a = p2; mul_b = cc; end
                    5'd13: begin mul_a = sb; mul_b = cc; end
                    5'd14: begin mul_a = p3; mul_b = sc; end
                    5'd15: begin mul_a = p4; mul_b = sc; end
                    5'd16: begin mul_a = cb; mul_b = sc; end
                    5'd17: begin mul_a = p3; mul_b = cc; end
                    5'd18: begin mul_a = p4; mul_b = cc; end
                    default: begin mul_a = cb; mul_b = cc; end
                endcase
            end
            default:
            begin
                mul_a = rx2_reg;
                mul_b = rt_reg;
            end
        endcase
        mul_q = rnd30(68'(mul_a) * 68'(mul_b));
    end

    assign divisor   = cos_mode_reg ? cos_div(i_reg) : sin_div(i_reg);
    assign last_term = cos_mode_reg ? (i_reg == 3'd5) : (i_reg == 3'd4);

    ezpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_TMUL),
        .dividend (mul_q),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        if (start)
            state_next = ST_BEGIN;
        else
        begin
            unique case (state_reg)
                ST_IDLE:  state_next = ST_IDLE;
                ST_BEGIN: state_next = ST_ANG;
                ST_ANG:   state_next = ST_X2;
                ST_X2:    state_next = ST_TMUL;
                ST_TMUL:  state_next = ST_TDIV;
                ST_TDIV:
                begin
                    if (div_done)
                    begin
                        if (!last_term)
                            state_next = ST_TMUL;
                        else if (cos_mode_reg)
                            state_next = ST_STORE;
                        else
                            state_next = ST_SIN;
                    end
                end
                ST_SIN:   state_next = ST_TMUL;
                ST_STORE: state_next = (k_reg == 2'd2) ? ST_PROD : ST_ANG;
                ST_PROD:  state_next = (j_reg == 5'(NPRD - 1)) ? ST_LOAD : ST_PROD;
                ST_LOAD:  state_next = ST_IDLE;
                default:  state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_BEGIN;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            cos_mode_reg <= 1'b0;
            neg_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (!start)
            begin
                unique case (state_reg)
                    ST_BEGIN: k_reg <= '0;
                    ST_ANG:
                    begin
                        neg_reg      <= ang_neg;
                        cos_mode_reg <= 1'b0;
                        i_reg        <= '0;
                    end
                    ST_TDIV:
                        if (div_done && !last_term)
                            i_reg <= i_reg + 1'b1;
                    ST_SIN:
                    begin
                        cos_mode_reg <= 1'b1;
                        i_reg        <= '0;
                    end
                    ST_STORE:
                    begin
                        k_reg <= k_reg + 1'b1;
                        j_reg <= '0;
                    end
                    ST_PROD:  j_reg <= j_reg + 1'b1;
                    default:  ;
                endcase
            end
        end
    end

    // payload side of the sequencer
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_ANG:
            begin
                rx_reg <= CW'(ang_fold) <<< 17;
                rt_reg <= Q30_ONE;
            end
            ST_X2:   rx2_reg <= mul_q;
            ST_TDIV:
                if (div_done)
                    rt_reg <= Q30_ONE - div_q;
            ST_SIN:
            begin
                rs_reg <= mul_q;
                rt_reg <= Q30_ONE;
            end
            ST_STORE:
            begin
                sin_reg[k_reg] <= neg_reg ? -rs_reg : rs_reg;
                cos_reg[k_reg] <= neg_reg ? -rt_reg : rt_reg;
            end
            ST_PROD: prd_reg[j_reg] <= mul_q;
            default: ;
        endcase
    end

    // matrix entries from the products; Q1..Q16 sit at prd_reg[4..19]
    assign r00 = prd_reg[4] - prd_reg[5];
    assign r01 = prd_reg[6] + prd_reg[7];
    assign r10 = -prd_reg[9] - prd_reg[10];
    assign r11 = prd_reg[12] - prd_reg[11];
    assign d1n = -prd_reg[6] - prd_reg[7];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            // rotation
            coef_reg[0][0][0] <= r00;
            coef_reg[0][0][1] <= r01;
            coef_reg[0][0][2] <= prd_reg[8];
            coef_reg[0][1][0] <= r10;
            coef_reg[0][1][1] <= r11;
            coef_reg[0][1][2] <= prd_reg[13];
            coef_reg[0][2][0] <= p3;
            coef_reg[0][2][1] <= -p4;
            coef_reg[0][2][2] <= cb;
            // by first angle
            coef_reg[1][0][0] <= d1n;
            coef_reg[1][0][1] <= r00;
            coef_reg[1][0][2] <= '0;
            coef_reg[1][1][0] <= prd_reg[11] - prd_reg[12];
            coef_reg[1][1][1] <= r10;
            coef_reg[1][1][2] <= '0;
            coef_reg[1][2][0] <= p4;
            coef_reg[1][2][1] <= p3;
            coef_reg[1][2][2] <= '0;
            // by second angle
            coef_reg[2][0][0] <= prd_reg[14];
            coef_reg[2][0][1] <= -prd_reg[15];
            coef_reg[2][0][2] <= prd_reg[16];
            coef_reg[2][1][0] <= prd_reg[17];
            coef_reg[2][1][1] <= -prd_reg[18];
            coef_reg[2][1][2] <= prd_reg[19];
            coef_reg[2][2][0] <= p1;
            coef_reg[2][2][1] <= -p2;
            coef_reg[2][2][2] <= -sb;
            // by third angle
            coef_reg[3][0][0] <= r10;
            coef_reg[3][0][1] <= r11;
            coef_reg[3][0][2] <= prd_reg[13];
            coef_reg[3][1][0] <= -r00;
            coef_reg[3][1][1] <= d1n;
            coef_reg[3][1][2] <= -prd_reg[8];
            coef_reg[3][2][0] <= '0;
            coef_reg[3][2][1] <= '0;
            coef_reg[3][2][2] <= '0;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign coef = coef_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ezpt_pipe.sv
// Point datapath: input register, 36 products, row sums, round and saturate.
`default_nettype none
module ezpt_pipe (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            hold,
    input  wire ezpt_pkg::coef_mat_t             coef,
    input  wire logic signed [ezpt_pkg::DW-1:0]  offset_x,
    input  wire logic signed [ezpt_pkg::DW-1:0]  offset_y,
    input  wire logic signed [ezpt_pkg::DW-1:0]  offset_z,
    ezpt_point_if.sink                           points,
    ezpt_result_if.source                        results
);
    import ezpt_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [DW-1:0] p_reg   [0:2];
    logic signed [PW-1:0] prd_reg [0:3][0:2][0:2];
    logic signed [AW-1:0] acc_reg [0:3][0:2];
    logic signed [DW-1:0] out_reg [0:3][0:2];
    logic signed [DW-1:0] off     [0:2];

    assign off[0] = offset_x;
    assign off[1] = offset_y;
    assign off[2] = offset_z;

    assign en4 = !v4_reg || results.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign points.ready = en1 && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= points.valid && !hold;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_reg[0] <= points.point_x;
            p_reg[1] <= points.point_y;
            p_reg[2] <= points.point_z;
        end
        if (en2)
        begin
            for (int k = 0; k < 4; k++)
                for (int r = 0; r < 3; r++)
                    for (int i = 0; i < 3; i++)
                        prd_reg[k][r][i] <= rnd14(66'($signed(coef[k][r][i])) *
                                                  66'(p_reg[i]));
        end
        if (en3)
        begin
            for (int k = 0; k < 4; k++)
                for (int r = 0; r < 3; r++)
                    acc_reg[k][r] <= AW'(prd_reg[k][r][0]) + AW'(prd_reg[k][r][1])
                                   + AW'(prd_reg[k][r][2])
                                   + ((k == 0) ? (AW'(off[r]) <<< 16) : AW'(0));
        end
        if (en4)
        begin
            for (int k = 0; k < 4; k++)
                for (int r = 0; r < 3; r++)
                    out_reg[k][r] <= rnd16_sat(acc_reg[k][r]);
        end
    end

    assign results.valid      = v4_reg;
    assign results.moved_x    = out_reg[0][0];
    assign results.moved_y    = out_reg[0][1];
    assign results.moved_z    = out_reg[0][2];
    assign results.d_first_x  = out_reg[1][0];
    assign results.d_first_y  = out_reg[1][1];
    assign results.d_first_z  = out_reg[1][2];
    assign results.d_second_x = out_reg[2][0];
    assign results.d_second_y = out_reg[2][1];
    assign results.d_second_z = out_reg[2][2];
    assign results.d_third_x  = out_reg[3][0];
    assign results.d_third_y  = out_reg[3][1];
    assign results.d_third_z  = out_reg[3][2];

endmodule
`default_nettype wire

FILE: hw/rtl/euler_zyz_point_transform_unit.sv
// Pipeline: input, product, row-sum and output registers; one point per cycle while
// results.ready does not stall it, with the 36 product lanes of the datapath in parallel.
// After reset, and after each angle write, the coefficient unit runs its sin/cos
// series through one shared multiplier and a reciprocal divider, with points.ready
// low. Reset clears the configuration registers to zero and the pipeline to empty.
`default_nettype none
module euler_zyz_point_transform_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ezpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                         cfg_data,
    ezpt_point_if.sink                               points,
    ezpt_result_if.source                            results
);
    import ezpt_pkg::*;

    logic signed [ANGW-1:0] angle_first_reg, angle_second_reg, angle_third_reg;
    logic signed [DW-1:0]   offset_x_reg, offset_y_reg, offset_z_reg;
    logic                   coef_busy;
    logic                   restart;
    coef_mat_t              coef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_first_reg  <= '0;
            angle_second_reg <= '0;
            angle_third_reg  <= '0;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            offset_z_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANGLE_FIRST:  angle_first_reg  <= cfg_data[ANGW-1:0];
                REG_ANGLE_SECOND: angle_second_reg <= cfg_data[ANGW-1:0];
                REG_ANGLE_THIRD:  angle_third_reg  <= cfg_data[ANGW-1:0];
                REG_OFFSET_X:     offset_x_reg     <= cfg_data;
                REG_OFFSET_Y:     offset_y_reg     <= cfg_data;
                REG_OFFSET_Z:     offset_z_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index == REG_ANGLE_FIRST ||
                                cfg_index == REG_ANGLE_SECOND ||
                                cfg_index == REG_ANGLE_THIRD);

    ezpt_coef u_coef (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (restart),
        .angle_first  (angle_first_reg),
        .angle_second (angle_second_reg),
        .angle_third  (angle_third_reg),
        .busy         (coef_busy),
        .coef         (coef)
    );

    ezpt_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (coef_busy),
        .coef     (coef),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .offset_z (offset_z_reg),
        .points   (points),
        .results  (results)
    );

endmodule
`default_nettype wire
